/* hw/rtl/wpid_pkg.sv */
// ----------------------------------------------------------------------------
// Windowed PID package
// Shared widths, register indexes and the stage-one payload type.
// ----------------------------------------------------------------------------
`default_nettype none

package wpid_pkg;

    localparam int ERR_W     = 24;
    localparam int DIFF_W    = ERR_W + 1;
    localparam int GAIN_W    = 16;
    localparam int LIMIT_W   = 31;
    localparam int ACC_W     = 32;
    localparam int DRIVE_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 31;

    localparam int P_PROD_W = ERR_W + GAIN_W;
    localparam int I_PROD_W = ACC_W + GAIN_W;
    localparam int D_PROD_W = DIFF_W + GAIN_W;
    localparam int TOTAL_W  = 50;
    localparam int FRAC_W   = 8;

    localparam int WINDOW_DEPTH_DEF = 16;
    localparam int DIFF_LAG_DEF     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 2'd3;

    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [ACC_W-1:0]  isum;
        logic signed [DIFF_W-1:0] diff;
    } wpid_win_t;

endpackage

`default_nettype wire

/* hw/rtl/wpid_cell.sv */
// ----------------------------------------------------------------------------
// Window history cell
// Holds one error sample and passes it to the next cell on every transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module wpid_cell
    import wpid_pkg::*;
(
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     shift_en,
    input  wire signed [ERR_W-1:0]  sample_in,
    output logic signed [ERR_W-1:0] sample_out
);

    logic signed [ERR_W-1:0] sample_reg;
    logic signed [ERR_W-1:0] sample_next;

    assign sample_next = shift_en ? sample_in : sample_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
        end else begin
            sample_reg <= sample_next;
        end
    end

    assign sample_out = sample_reg;

endmodule

`default_nettype wire

/* hw/rtl/wpid_window.sv */
// ----------------------------------------------------------------------------
// Windowed integral and lagged difference
// Chain of history cells, the clamped running sum and the stage-one register.
// ----------------------------------------------------------------------------
`default_nettype none

module wpid_window
    import wpid_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int DIFF_LAG     = DIFF_LAG_DEF
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     accept,
    input  wire signed [ERR_W-1:0]  error_sample,
    input  wire [LIMIT_W-1:0]       integral_limit,
    output wpid_win_t               win_out
);

    // Cell k holds the sample from k+1 transfers ago; the last cell is the
    // oldest, which is the one leaving the window.
    localparam int LAG_MOD = DIFF_LAG % WINDOW_DEPTH;
    localparam int LAG_TAP = (LAG_MOD == 0) ? (WINDOW_DEPTH - 1) : (LAG_MOD - 1);

    logic signed [ERR_W-1:0] chain [WINDOW_DEPTH];

    genvar k;
    generate
        for (k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
            if (k == 0) begin : g_head
                wpid_cell u_cell (
                    .aclk       (aclk),
                    .aresetn    (aresetn),
                    .shift_en   (accept),
                    .sample_in  (error_sample),
                    .sample_out (chain[k])
                );
            end else begin : g_body
                wpid_cell u_cell (
                    .aclk       (aclk),
                    .aresetn    (aresetn),
                    .shift_en   (accept),
                    .sample_in  (chain[k-1]),
                    .sample_out (chain[k])
                );
            end
        end
    endgenerate

    logic signed [ACC_W-1:0]  accum_reg;
    logic signed [ACC_W-1:0]  accum_next;
    logic signed [ACC_W:0]    raw_sum;
    logic signed [ACC_W:0]    pos_lim;
    logic signed [ACC_W:0]    neg_lim;
    logic signed [ACC_W-1:0]  clamped;
    logic signed [DIFF_W-1:0] diff;
    wpid_win_t                win_reg;
    wpid_win_t                win_next;

    assign raw_sum = (ACC_W+1)'(accum_reg) - (ACC_W+1)'(chain[WINDOW_DEPTH-1])
                   + (ACC_W+1)'(error_sample);
    assign pos_lim = $signed({2'b00, integral_limit});
    assign neg_lim = -pos_lim;

    always_comb begin
        if (raw_sum > pos_lim) begin
            clamped = pos_lim[ACC_W-1:0];
        end else if (raw_sum < neg_lim) begin
            clamped = neg_lim[ACC_W-1:0];
        end else begin
            clamped = raw_sum[ACC_W-1:0];
        end
    end

    assign diff = DIFF_W'(error_sample) - DIFF_W'(chain[LAG_TAP]);

    assign accum_next = accept ? clamped : accum_reg;

    always_comb begin
        win_next = win_reg;
        if (accept) begin
            win_next.err  = error_sample;
            win_next.isum = clamped;
            win_next.diff = diff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg <= '0;
        end else begin
            accum_reg <= accum_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    assign win_out = win_reg;

endmodule

`default_nettype wire

/* hw/rtl/windowed_pid_controller_unit.sv */
// ----------------------------------------------------------------------------
// Windowed PID controller
// One PID step per error sample with a windowed, clamped integral term.
// ----------------------------------------------------------------------------
//  Channel  | Ports                                  | Role
//  ---------+----------------------------------------+--------------------------
//  input    | s_valid s_ready s_error_sample         | error sample per tick
//  result   | m_valid m_ready m_drive_value          | saturated PID output
//           | m_out_saturated                        |
//  config   | cfg_wr_en cfg_index cfg_wr_data        | gains and integral limit
//
//  One sample is taken per cycle while the result side does not stall; each
//  transfer passes the window, product and drive registers in turn. The rate is
//  set by the running-sum loop in the window stage, closed through one register.
//  Reset clears the history cells, the running sum, the configuration
//  registers and the stage valid flags; the data registers are not reset.
//  Each stage holds while the stage after it is full and stalled, so an
//  input transfer is still taken while a result waits, as long as a stage
//  is free.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_pid_controller_unit
    import wpid_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int DIFF_LAG     = DIFF_LAG_DEF
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]       cfg_index,
    input  wire [CFG_DAT_W-1:0]       cfg_wr_data,
    input  wire                       s_valid,
    output logic                      s_ready,
    input  wire signed [ERR_W-1:0]    s_error_sample,
    output logic                      m_valid,
    input  wire                       m_ready,
    output logic signed [DRIVE_W-1:0] m_drive_value,
    output logic                      m_out_saturated
);

    // Configuration registers.
    logic signed [GAIN_W-1:0] prop_gain_reg,  prop_gain_next;
    logic signed [GAIN_W-1:0] int_gain_reg,   int_gain_next;
    logic signed [GAIN_W-1:0] deriv_gain_reg, deriv_gain_next;
    logic [LIMIT_W-1:0]       limit_reg,      limit_next;

    always_comb begin
        prop_gain_next  = prop_gain_reg;
        int_gain_next   = int_gain_reg;
        deriv_gain_next = deriv_gain_reg;
        limit_next      = limit_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_PROP_GAIN:      prop_gain_next  = cfg_wr_data[GAIN_W-1:0];
                REG_INT_GAIN:       int_gain_next   = cfg_wr_data[GAIN_W-1:0];
                REG_DERIV_GAIN:     deriv_gain_next = cfg_wr_data[GAIN_W-1:0];
                REG_INTEGRAL_LIMIT: limit_next      = cfg_wr_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= '0;
            int_gain_reg   <= '0;
            deriv_gain_reg <= '0;
            limit_reg      <= '0;
        end else begin
            prop_gain_reg  <= prop_gain_next;
            int_gain_reg   <= int_gain_next;
            deriv_gain_reg <= deriv_gain_next;
            limit_reg      <= limit_next;
        end
    end

    // Stage occupancy and advance conditions.
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic load2, load3, accept;

    assign load3   = v2_reg && (!v3_reg || m_ready);
    assign load2   = v1_reg && (!v2_reg || load3);
    assign s_ready = !v1_reg || load2;
    assign accept  = s_valid && s_ready;

    assign v1_next = accept ? 1'b1 : (load2 ? 1'b0 : v1_reg);
    assign v2_next = load2 ? 1'b1 : (load3 ? 1'b0 : v2_reg);
    assign v3_next = load3 ? 1'b1 : (m_ready ? 1'b0 : v3_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Stage one: history chain, clamped sum and lagged difference.
    wpid_win_t win;

    wpid_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .DIFF_LAG     (DIFF_LAG)
    ) u_window (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .error_sample   (s_error_sample),
        .integral_limit (limit_reg),
        .win_out        (win)
    );

    // Stage two: the three gain products, each registered.
    logic signed [P_PROD_W-1:0] p_prod_reg, p_prod_next;
    logic signed [I_PROD_W-1:0] i_prod_reg, i_prod_next;
    logic signed [D_PROD_W-1:0] d_prod_reg, d_prod_next;

    always_comb begin
        p_prod_next = p_prod_reg;
        i_prod_next = i_prod_reg;
        d_prod_next = d_prod_reg;
        if (load2) begin
            p_prod_next = win.err  * prop_gain_reg;
            i_prod_next = win.isum * int_gain_reg;
            d_prod_next = win.diff * deriv_gain_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p_prod_reg <= p_prod_next;
        i_prod_reg <= i_prod_next;
        d_prod_reg <= d_prod_next;
    end

    // Stage three: sum, drop the fraction (floor) and saturate.
    logic signed [TOTAL_W-1:0]        total;
    logic signed [TOTAL_W-FRAC_W-1:0] shifted;
    logic                             overflow;
    logic signed [DRIVE_W-1:0]        drive_sat;
    logic signed [DRIVE_W-1:0]        drive_reg, drive_next;
    logic                             sat_reg, sat_next;

    assign total   = TOTAL_W'(p_prod_reg) + TOTAL_W'(i_prod_reg) + TOTAL_W'(d_prod_reg);
    assign shifted = total[TOTAL_W-1:FRAC_W];

    // The value fits when every bit above the result's sign bit repeats it.
    assign overflow = (shifted[TOTAL_W-FRAC_W-1:DRIVE_W-1] != '0) &&
                      (shifted[TOTAL_W-FRAC_W-1:DRIVE_W-1] != '1);

    always_comb begin
        if (!overflow) begin
            drive_sat = shifted[DRIVE_W-1:0];
        end else if (shifted[TOTAL_W-FRAC_W-1]) begin
            drive_sat = {1'b1, {(DRIVE_W-1){1'b0}}};
        end else begin
            drive_sat = {1'b0, {(DRIVE_W-1){1'b1}}};
        end
    end

    assign drive_next = load3 ? drive_sat : drive_reg;
    assign sat_next   = load3 ? overflow  : sat_reg;

    always_ff @(posedge aclk) begin
        drive_reg <= drive_next;
        sat_reg   <= sat_next;
    end

    assign m_valid         = v3_reg;
    assign m_drive_value   = drive_reg;
    assign m_out_saturated = sat_reg;

endmodule

`default_nettype wire

/* hw/rtl/wpid_checker.sv */
// ----------------------------------------------------------------------------
// Windowed PID port checker
// Watches the top-level ports for result-channel and latency slips.
// ----------------------------------------------------------------------------
`default_nettype none

module wpid_checker
    import wpid_pkg::*;
(
    input wire                      aclk,
    input wire                      aresetn,
    input wire                      s_valid,
    input wire                      s_ready,
    input wire                      m_valid,
    input wire                      m_ready,
    input wire signed [DRIVE_W-1:0] m_drive_value,
    input wire                      m_out_saturated
);

    // No result may be offered straight after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered after reset");

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive_value)
            && $stable(m_out_saturated))
        else $error("stalled result changed");

    // A clipped result sits at one of the two rails.
    a_sat_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_saturated |->
            (m_drive_value == 32'sh7fffffff) || (m_drive_value == 32'sh80000000))
        else $error("saturation flag without rail value");

    // With the result side ready after a transfer, a result must be offered.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("result missing after transfer");

endmodule

bind windowed_pid_controller_unit wpid_checker u_wpid_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_drive_value   (m_drive_value),
    .m_out_saturated (m_out_saturated)
);

`default_nettype wire

/* verif/windowed_pid_controller_unit_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Windowed PID controller checker
// Follows register writes and sample transfers, predicts each drive value
// from its own copy of the error window and running sum, and compares every
// result transfer against the oldest prediction still waiting.
// ----------------------------------------------------------------------------

module windowed_pid_controller_unit_checker
    import wpid_pkg::*;
(
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]       cfg_index,
    input  wire [CFG_DAT_W-1:0]       cfg_wr_data,
    input  wire                       s_valid,
    input  wire                       s_ready,
    input  wire signed [ERR_W-1:0]    s_error_sample,
    input  wire                       m_valid,
    input  wire                       m_ready,
    input  wire signed [DRIVE_W-1:0]  m_drive_value,
    input  wire                       m_out_saturated,
    output int                        error_count,
    output int                        outstanding
);

    localparam int     DEPTH     = WINDOW_DEPTH_DEF;
    localparam int     LAG       = DIFF_LAG_DEF % WINDOW_DEPTH_DEF;
    localparam longint DRIVE_MAX = 64'sd2147483647;
    localparam longint DRIVE_MIN = -64'sd2147483648;

    typedef struct {
        logic signed [DRIVE_W-1:0] drive;
        logic                      saturated;
    } drive_result_t;

    drive_result_t             expected_drive_q[$];

    logic signed [GAIN_W-1:0]  kp;
    logic signed [GAIN_W-1:0]  ki;
    logic signed [GAIN_W-1:0]  kd;
    logic [LIMIT_W-1:0]        sum_limit;
    logic signed [ERR_W-1:0]   err_ring [DEPTH];
    int unsigned               ring_slot;
    longint                    window_sum;

    // Advances the error window by one sample and returns the drive it gives.
    function automatic drive_result_t pid_tick(input logic signed [ERR_W-1:0] sample);
        longint        e;
        longint        lim;
        longint        sum;
        longint        total;
        longint        shifted;
        int unsigned   back;
        drive_result_t res;

        e    = sample;
        lim  = longint'(sum_limit);
        back = (ring_slot + DEPTH - LAG) % DEPTH;

        // The entry about to be overwritten leaves the window as e enters it.
        sum = window_sum - longint'(err_ring[ring_slot]) + e;
        if (sum > lim) begin
            sum = lim;
        end else if (sum < -lim) begin
            sum = -lim;
        end
        window_sum = sum;

        total = e * longint'(kp) + sum * longint'(ki)
              + (e - longint'(err_ring[back])) * longint'(kd);

        err_ring[ring_slot] = sample;
        ring_slot           = (ring_slot + 1) % DEPTH;

        shifted       = total >>> FRAC_W;
        res.saturated = 1'b0;
        if (shifted > DRIVE_MAX) begin
            shifted       = DRIVE_MAX;
            res.saturated = 1'b1;
        end else if (shifted < DRIVE_MIN) begin
            shifted       = DRIVE_MIN;
            res.saturated = 1'b1;
        end
        res.drive = DRIVE_W'(shifted);
        return res;
    endfunction

    always @(posedge aclk) begin : track_and_compare
        drive_result_t want;

        if (!aresetn) begin
            kp         = '0;
            ki         = '0;
            kd         = '0;
            sum_limit  = '0;
            ring_slot  = 0;
            window_sum = 0;
            for (int i = 0; i < DEPTH; i++) begin
                err_ring[i] = '0;
            end
            expected_drive_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_PROP_GAIN: begin
                        kp = cfg_wr_data[GAIN_W-1:0];
                    end
                    REG_INT_GAIN: begin
                        ki = cfg_wr_data[GAIN_W-1:0];
                    end
                    REG_DERIV_GAIN: begin
                        kd = cfg_wr_data[GAIN_W-1:0];
                    end
                    REG_INTEGRAL_LIMIT: begin
                        sum_limit = cfg_wr_data[LIMIT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            // Results are retired before this edge's sample is queued, so a
            // stray result can never consume a prediction made at the same edge.
            if (m_valid && m_ready) begin
                if (expected_drive_q.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("unexpected result transfer: drive %0d saturated %0b",
                                 m_drive_value, m_out_saturated);
                    end
                end else begin
                    want = expected_drive_q.pop_front();
                    if (m_drive_value !== want.drive
                            || m_out_saturated !== want.saturated) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display({"result mismatch: drive exp %0d got %0d,",
                                      " saturated exp %0b got %0b"},
                                     want.drive, m_drive_value,
                                     want.saturated, m_out_saturated);
                        end
                    end
                end
            end

            if (s_valid && s_ready) begin
                expected_drive_q.push_back(pid_tick(s_error_sample));
            end
        end
        outstanding = expected_drive_q.size();
    end

endmodule

/* verif/windowed_pid_controller_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Windowed PID controller testbench
// Drives error samples and gain/limit settings into the controller with
// random gaps and back-pressure; the checker beside it predicts and compares
// every result and the verdict is given here.
// ----------------------------------------------------------------------------

module windowed_pid_controller_unit_tb;

    import wpid_pkg::*;

    localparam logic signed [ERR_W-1:0]  ERR_MAX   = {1'b0, {(ERR_W-1){1'b1}}};
    localparam logic signed [ERR_W-1:0]  ERR_MIN   = {1'b1, {(ERR_W-1){1'b0}}};
    localparam logic signed [GAIN_W-1:0] GAIN_MAX  = {1'b0, {(GAIN_W-1){1'b1}}};
    localparam logic signed [GAIN_W-1:0] GAIN_MIN  = {1'b1, {(GAIN_W-1){1'b0}}};
    localparam logic signed [GAIN_W-1:0] GAIN_ONE  = 16'sd256;
    localparam logic [LIMIT_W-1:0]       LIMIT_MAX = {LIMIT_W{1'b1}};
    localparam int                       RANDOM_SAMPLES = 1150;

    logic                      aclk           = 1'b0;
    logic                      aresetn        = 1'b0;
    logic                      cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index      = '0;
    logic [CFG_DAT_W-1:0]      cfg_wr_data    = '0;
    logic                      s_valid        = 1'b0;
    logic signed [ERR_W-1:0]   s_error_sample = '0;
    logic                      m_ready        = 1'b0;
    wire                       s_ready;
    wire                       m_valid;
    wire signed [DRIVE_W-1:0]  m_drive_value;
    wire                       m_out_saturated;

    int                        error_count;
    int                        outstanding;
    bit                        steady_flow = 1'b0;
    int                        ready_hold  = 0;
    int                        samples_sent = 0;

    windowed_pid_controller_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_error_sample  (s_error_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive_value   (m_drive_value),
        .m_out_saturated (m_out_saturated)
    );

    windowed_pid_controller_unit_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_error_sample  (s_error_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive_value   (m_drive_value),
        .m_out_saturated (m_out_saturated),
        .error_count     (error_count),
        .outstanding     (outstanding)
    );

    always #10 aclk = ~aclk;

    // Result side back-pressure: mostly short stalls, now and then a long one.
    always @(negedge aclk) begin
        if (steady_flow) begin
            m_ready <= 1'b1;
            ready_hold = 0;
        end else if (ready_hold > 0) begin
            ready_hold--;
        end else if (!m_ready || $urandom_range(0, 99) < 60) begin
            m_ready <= 1'b1;
            ready_hold = $urandom_range(0, 6);
        end else begin
            m_ready <= 1'b0;
            ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 3);
        end
    end

    function automatic int sample_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Modes: 0 full range, 1 drifting positive, 2 drifting negative, 3 small.
    function automatic logic signed [ERR_W-1:0] random_error(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            case ($urandom_range(0, 4))
                0:       return ERR_MAX;
                1:       return ERR_MIN;
                2:       return '0;
                3:       return '1;
                default: return ERR_W'(1);
            endcase
        end
        case (mode)
            1:       return ERR_W'($urandom_range(0, 20000));
            2:       return ERR_W'(-int'($urandom_range(0, 20000)));
            3:       return ERR_W'(int'($urandom_range(0, 8192)) - 4096);
            default: return ERR_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [GAIN_W-1:0] random_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            case ($urandom_range(0, 4))
                0:       return GAIN_MAX;
                1:       return GAIN_MIN;
                2:       return '0;
                3:       return GAIN_ONE;
                default: return -GAIN_ONE;
            endcase
        end else if (r < 50) begin
            return GAIN_W'(int'($urandom_range(0, 1024)) - 512);
        end
        return GAIN_W'($urandom);
    endfunction

    function automatic logic [LIMIT_W-1:0] random_limit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return LIMIT_MAX;
            2:       return LIMIT_W'($urandom_range(0, 4095));
            3:       return LIMIT_W'($urandom_range(0, 1 << 20));
            default: return LIMIT_W'($urandom);
        endcase
    endfunction

    // All tasks below are entered just after a falling edge.
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(negedge aclk);
    endtask

    task automatic program_regs(input logic signed [GAIN_W-1:0] p_gain,
                                input logic signed [GAIN_W-1:0] i_gain,
                                input logic signed [GAIN_W-1:0] d_gain,
                                input logic [LIMIT_W-1:0]       limit);
        put_reg(REG_PROP_GAIN,      CFG_DAT_W'(p_gain));
        put_reg(REG_INT_GAIN,       CFG_DAT_W'(i_gain));
        put_reg(REG_DERIV_GAIN,     CFG_DAT_W'(d_gain));
        put_reg(REG_INTEGRAL_LIMIT, CFG_DAT_W'(limit));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_error(input logic signed [ERR_W-1:0] value);
        int gap;
        gap = sample_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_error_sample <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        samples_sent++;
        @(negedge aclk);
    endtask

    // Lets the pipeline empty before registers change or the run ends.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    initial begin
        int burst;
        int mode;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Registers at their reset values give a zero drive.
        send_error(ERR_MAX);
        send_error(ERR_MIN);
        wait_drained();

        program_regs(GAIN_ONE, '0, '0, LIMIT_MAX);
        send_error(ERR_MAX);
        send_error(ERR_MIN);
        send_error('1);
        send_error(ERR_W'(1));
        send_error('0);
        wait_drained();

        // Largest gains on a full-scale sum drive the output to saturation.
        program_regs(GAIN_MAX, GAIN_MAX, GAIN_MAX, LIMIT_MAX);
        repeat (4) send_error(ERR_MAX);
        wait_drained();

        program_regs(GAIN_MIN, GAIN_MIN, GAIN_MIN, LIMIT_MAX);
        repeat (3) send_error(ERR_MAX);
        wait_drained();

        // A zero limit holds the sum at zero.
        program_regs('0, GAIN_ONE, '0, '0);
        repeat (3) send_error(ERR_MIN);
        wait_drained();

        // Build up a sum, then lower the limit under it.
        program_regs('0, GAIN_ONE, GAIN_ONE, LIMIT_MAX);
        repeat (3) send_error(24'sd1000000);
        wait_drained();
        program_regs('0, GAIN_ONE, GAIN_ONE, 31'd100);
        send_error(24'sd1000000);
        send_error(-24'sd3);
        wait_drained();

        samples_sent = 0;
        while (samples_sent < RANDOM_SAMPLES) begin
            wait_drained();
            program_regs(random_gain(), random_gain(), random_gain(), random_limit());
            steady_flow <= ($urandom_range(0, 4) == 0);
            mode  = $urandom_range(0, 3);
            burst = $urandom_range(40, 120);
            repeat (burst) send_error(random_error(mode));
        end
        steady_flow <= 1'b0;
        wait_drained();

        if (error_count == 0 && outstanding == 0) begin
            $display("windowed_pid_controller_unit regression: pass");
        end else begin
            $display("windowed_pid_controller_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("windowed_pid_controller_unit regression: fail");
        $finish;
    end

endmodule

/* windowed_pid_controller_unit.f */
hw/rtl/wpid_pkg.sv
hw/rtl/wpid_cell.sv
hw/rtl/wpid_window.sv
hw/rtl/windowed_pid_controller_unit.sv
hw/rtl/wpid_checker.sv
verif/windowed_pid_controller_unit_checker.sv
verif/windowed_pid_controller_unit_tb.sv
